FILE: hdl/ecsm_pkg.sv
`timescale 1ns / 1ps

package ecsm_pkg;

  localparam int FIELD_BITS_DEF  = 32;
  localparam int SCALAR_BITS_DEF = 32;
  localparam int IO_W            = 32;
  localparam int MAX_W           = 64;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIME   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 1'd1;

  localparam logic [IO_W-1:0] PRIME_RST   = 32'd17;
  localparam logic [IO_W-1:0] CURVE_A_RST = 32'd2;

  typedef struct packed {
    logic [IO_W-1:0] scalar;
    logic [IO_W-1:0] point_x;
    logic [IO_W-1:0] point_y;
  } ecsm_in_t;

  typedef struct packed {
    logic [IO_W-1:0] result_x;
    logic [IO_W-1:0] result_y;
    logic            status;
  } ecsm_out_t;

  // command from the sequencer to the serial unit
  typedef struct packed {
    logic start;
    logic div;
  } ecsm_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_X,
    ST_RED_Y,
    ST_RED_A,
    ST_FIND,
    ST_LOOP,
    ST_DBL,
    ST_DBL_SQ,
    ST_DBL_N2,
    ST_DBL_N3,
    ST_DBL_NA,
    ST_ADD,
    ST_INV,
    ST_LAM,
    ST_LSQ,
    ST_NEWX,
    ST_DIFF,
    ST_MY,
    ST_NEWY
  } ecsm_state_t;

  // operands below p, carried at the widest field width
  function automatic logic [MAX_W-1:0] mod_add(input logic [MAX_W-1:0] x,
                                               input logic [MAX_W-1:0] y,
                                               input logic [MAX_W-1:0] p);
    logic [MAX_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[MAX_W-1:0];
  endfunction

  function automatic logic [MAX_W-1:0] mod_sub(input logic [MAX_W-1:0] x,
                                               input logic [MAX_W-1:0] y,
                                               input logic [MAX_W-1:0] p);
    logic [MAX_W-1:0] d;
    d = x - y;
    if (x < y) begin
      d = d + p;
    end
    return d;
  endfunction

endpackage

FILE: hdl/ecsm_serial_unit.sv
`timescale 1ns / 1ps

// Bit-serial modular engine: takes the bits of n MSB first; for each bit it shifts and doubles, then adds.
// div mode: divides n by d (remainder in rem) and accumulates q*a mod p.
// multiply mode: accumulates n*a mod p.
module ecsm_serial_unit #(
  parameter int FIELD_BITS = ecsm_pkg::FIELD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ecsm_pkg::ecsm_cmd_t   cmd,
  input  logic [FIELD_BITS-1:0] n_in,
  input  logic [FIELD_BITS-1:0] d_in,
  input  logic [FIELD_BITS-1:0] a_in,
  input  logic [FIELD_BITS-1:0] p_in,
  output logic                  done,
  output logic [FIELD_BITS-1:0] rem,
  output logic [FIELD_BITS-1:0] acc
);

  localparam int FW = FIELD_BITS;
  localparam int CW = $clog2(FW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          div_r, div_nxt;
  logic          q_r, q_nxt;
  logic [FW-1:0] n_r, n_nxt;
  logic [FW-1:0] d_r, d_nxt;
  logic [FW-1:0] a_r, a_nxt;
  logic [FW-1:0] p_r, p_nxt;
  logic [FW-1:0] rem_r, rem_nxt;
  logic [FW-1:0] acc_r, acc_nxt;
  logic [FW:0]   cand;
  logic [FW:0]   cand_sub;
  logic          ge;

  function automatic logic [FW-1:0] fadd(input logic [FW-1:0] x, input logic [FW-1:0] y,
                                         input logic [FW-1:0] p);
    return FW'(ecsm_pkg::mod_add(ecsm_pkg::MAX_W'(x), ecsm_pkg::MAX_W'(y),
                                 ecsm_pkg::MAX_W'(p)));
  endfunction

  assign cand     = {rem_r, n_r[FW-1]};
  assign ge       = cand >= {1'b0, d_r};
  assign cand_sub = cand - {1'b0, d_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    q_nxt     = q_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    a_nxt     = a_r;
    p_nxt     = p_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    if (cmd.start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt   = '0;
      div_nxt   = cmd.div;
      n_nxt     = n_in;
      d_nxt     = d_in;
      a_nxt     = a_in;
      p_nxt     = p_in;
      rem_nxt   = '0;
      acc_nxt   = '0;
    end else if (busy_r) begin
      if (!phase_r) begin
        // shift in the next dividend bit and double the accumulator
        rem_nxt   = (div_r && ge) ? cand_sub[FW-1:0] : cand[FW-1:0];
        q_nxt     = div_r ? ge : n_r[FW-1];
        n_nxt     = {n_r[FW-2:0], 1'b0};
        acc_nxt   = fadd(acc_r, acc_r, p_r);
        phase_nxt = 1'b1;
      end else begin
        acc_nxt   = fadd(acc_r, q_r ? a_r : '0, p_r);
        phase_nxt = 1'b0;
        if (cnt_r == CW'(FW - 1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    cnt_r   <= cnt_nxt;
    div_r   <= div_nxt;
    q_r     <= q_nxt;
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    a_r     <= a_nxt;
    p_r     <= p_nxt;
    rem_r   <= rem_nxt;
    acc_r   <= acc_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign acc  = acc_r;

endmodule

FILE: hdl/ec_point_scalar_multiply_top.sv
`timescale 1ns / 1ps

// Scalar multiplication k*P on y^2 = x^3 + a*x + b over GF(p), affine,
// left-to-right double-and-add; (0,0) is the point at infinity. A beat is
// taken when start is high and busy is low; the result appears for one
// cycle with out_valid and cannot be held off, so capture it then. A zero
// scalar (status 1) or a modulus below two answers on the next cycle.
// Otherwise every multiply, every Euclid step of an inversion and every input
// reduction runs on one shared bit-serial unit; an inversion takes up to
// about 1.5*FIELD_BITS Euclid steps (about 19 on average at 32 bits). A
// doubling needs one inversion and four multiplies, an addition one
// inversion and three. prime_modulus and curve_a are written through cfg_we;
// the user must write them only while the block is idle; the block itself
// does not enforce this.
module ec_point_scalar_multiply_top #(
  parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
  parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  ecsm_pkg::ecsm_in_t                 in_data,
  output logic                               out_valid,
  output ecsm_pkg::ecsm_out_t                out_data,
  input  logic                               cfg_we,
  input  logic [ecsm_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [ecsm_pkg::IO_W-1:0]          cfg_wdata
);

  localparam int FW = FIELD_BITS;
  localparam int SB = SCALAR_BITS;
  localparam int IW = $clog2(SB);

  ecsm_pkg::ecsm_state_t state_r, state_nxt;

  logic          launched_r, launched_nxt;
  logic          is_add_r, is_add_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [SB-1:0] k_r, k_nxt;
  logic [FW-1:0] prime_r, prime_nxt;
  logic [FW-1:0] curve_a_r, curve_a_nxt;
  logic [FW-1:0] p_r, p_nxt;
  logic [FW-1:0] x_r, x_nxt;
  logic [FW-1:0] y_r, y_nxt;
  logic [FW-1:0] ared_r, ared_nxt;
  logic [FW-1:0] bx_r, bx_nxt;
  logic [FW-1:0] by_r, by_nxt;
  logic [FW-1:0] rx_r, rx_nxt;
  logic [FW-1:0] ry_r, ry_nxt;
  logic [FW-1:0] num_r, num_nxt;
  logic [FW-1:0] t_r, t_nxt;
  logic [FW-1:0] s_r, s_nxt;
  logic [FW-1:0] lam_r, lam_nxt;
  logic [FW-1:0] inv_r, inv_nxt;
  logic [FW-1:0] r0_r, r0_nxt;
  logic [FW-1:0] r1_r, r1_nxt;
  logic [FW-1:0] t0_r, t0_nxt;
  logic [FW-1:0] t1_r, t1_nxt;
  logic [FW-1:0] tx_r, tx_nxt;
  logic          out_valid_r, out_valid_nxt;
  ecsm_pkg::ecsm_out_t out_r, out_nxt;

  ecsm_pkg::ecsm_cmd_t u_cmd;
  logic          u_start;
  logic          u_div;
  logic [FW-1:0] u_n, u_d, u_a;
  logic          u_done;
  logic [FW-1:0] u_rem, u_acc;
  ecsm_pkg::ecsm_state_t after_st;

  function automatic logic [FW-1:0] fadd(input logic [FW-1:0] x, input logic [FW-1:0] y,
                                         input logic [FW-1:0] p);
    return FW'(ecsm_pkg::mod_add(ecsm_pkg::MAX_W'(x), ecsm_pkg::MAX_W'(y),
                                 ecsm_pkg::MAX_W'(p)));
  endfunction

  function automatic logic [FW-1:0] fsub(input logic [FW-1:0] x, input logic [FW-1:0] y,
                                         input logic [FW-1:0] p);
    return FW'(ecsm_pkg::mod_sub(ecsm_pkg::MAX_W'(x), ecsm_pkg::MAX_W'(y),
                                 ecsm_pkg::MAX_W'(p)));
  endfunction

  ecsm_serial_unit #(
    .FIELD_BITS(FIELD_BITS)
  ) u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (u_cmd),
    .n_in (u_n),
    .d_in (u_d),
    .a_in (u_a),
    .p_in (p_r),
    .done (u_done),
    .rem  (u_rem),
    .acc  (u_acc)
  );

  assign u_cmd = '{start: u_start, div: u_div};

  // where a finished doubling or addition goes next
  assign after_st = (!is_add_r && k_r[idx_r]) ? ecsm_pkg::ST_ADD : ecsm_pkg::ST_LOOP;

  // operands for the serial unit
  always_comb begin
    u_n = '0;
    u_d = p_r;
    u_a = '0;
    u_div = 1'b0;
    unique case (state_r)
      ecsm_pkg::ST_RED_X: begin
        u_n = x_r;
        u_div = 1'b1;
      end
      ecsm_pkg::ST_RED_Y: begin
        u_n = y_r;
        u_div = 1'b1;
      end
      ecsm_pkg::ST_RED_A: begin
        u_n = curve_a_r;
        u_div = 1'b1;
      end
      ecsm_pkg::ST_DBL_SQ: begin
        u_n = rx_r;
        u_a = rx_r;
      end
      ecsm_pkg::ST_INV: begin
        u_n = r0_r;
        u_d = r1_r;
        u_a = t1_r;
        u_div = 1'b1;
      end
      ecsm_pkg::ST_LAM: begin
        u_n = inv_r;
        u_a = num_r;
      end
      ecsm_pkg::ST_LSQ: begin
        u_n = lam_r;
        u_a = lam_r;
      end
      ecsm_pkg::ST_MY: begin
        u_n = s_r;
        u_a = lam_r;
      end
      default: begin
        u_n = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    launched_nxt  = launched_r;
    is_add_nxt    = is_add_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    prime_nxt     = prime_r;
    curve_a_nxt   = curve_a_r;
    p_nxt         = p_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    ared_nxt      = ared_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    num_nxt       = num_r;
    t_nxt         = t_r;
    s_nxt         = s_r;
    lam_nxt       = lam_r;
    inv_nxt       = inv_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    tx_nxt        = tx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    u_start       = 1'b0;

    if (cfg_we) begin
      unique case (cfg_addr)
        ecsm_pkg::CFG_PRIME:   prime_nxt   = FW'(cfg_wdata);
        ecsm_pkg::CFG_CURVE_A: curve_a_nxt = FW'(cfg_wdata);
        default:               prime_nxt   = prime_r;
      endcase
    end

    unique case (state_r)
      ecsm_pkg::ST_IDLE: begin
        if (start) begin
          if (SB'(in_data.scalar) == '0) begin
            out_nxt.result_x = in_data.point_x;
            out_nxt.result_y = in_data.point_y;
            out_nxt.status   = 1'b1;
            out_valid_nxt    = 1'b1;
          end else if (prime_r < FW'(2)) begin
            out_nxt       = '0;
            out_valid_nxt = 1'b1;
          end else begin
            k_nxt        = SB'(in_data.scalar);
            p_nxt        = prime_r;
            x_nxt        = FW'(in_data.point_x);
            y_nxt        = FW'(in_data.point_y);
            idx_nxt      = IW'(SB - 1);
            launched_nxt = 1'b0;
            state_nxt    = ecsm_pkg::ST_RED_X;
          end
        end
      end
      ecsm_pkg::ST_RED_X, ecsm_pkg::ST_RED_Y, ecsm_pkg::ST_RED_A: begin
        if (!launched_r) begin
          u_start      = 1'b1;
          launched_nxt = 1'b1;
        end else if (u_done) begin
          launched_nxt = 1'b0;
          if (state_r == ecsm_pkg::ST_RED_X) begin
            bx_nxt    = u_rem;
            rx_nxt    = u_rem;
            state_nxt = ecsm_pkg::ST_RED_Y;
          end else if (state_r == ecsm_pkg::ST_RED_Y) begin
            by_nxt    = u_rem;
            ry_nxt    = u_rem;
            state_nxt = ecsm_pkg::ST_RED_A;
          end else begin
            ared_nxt  = u_rem;
            state_nxt = ecsm_pkg::ST_FIND;
          end
        end
      end
      ecsm_pkg::ST_FIND: begin
        // walk down to the leading one of the scalar
        if (k_r[idx_r] || idx_r == '0) begin
          state_nxt = ecsm_pkg::ST_LOOP;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      ecsm_pkg::ST_LOOP: begin
        if (idx_r == '0) begin
          out_nxt.result_x = ecsm_pkg::IO_W'(rx_r);
          out_nxt.result_y = ecsm_pkg::IO_W'(ry_r);
          out_nxt.status   = 1'b0;
          out_valid_nxt    = 1'b1;
          state_nxt        = ecsm_pkg::ST_IDLE;
        end else begin
          idx_nxt    = idx_r - 1'b1;
          is_add_nxt = 1'b0;
          state_nxt  = ecsm_pkg::ST_DBL;
        end
      end
      ecsm_pkg::ST_DBL: begin
        if (ry_r == '0) begin
          rx_nxt    = '0;
          ry_nxt    = '0;
          state_nxt = after_st;
        end else begin
          s_nxt     = fadd(rx_r, rx_r, p_r);
          state_nxt = ecsm_pkg::ST_DBL_SQ;
        end
      end
      ecsm_pkg::ST_DBL_SQ: begin
        if (!launched_r) begin
          u_start      = 1'b1;
          launched_nxt = 1'b1;
        end else if (u_done) begin
          launched_nxt = 1'b0;
          num_nxt      = u_acc;
          state_nxt    = ecsm_pkg::ST_DBL_N2;
        end
      end
      ecsm_pkg::ST_DBL_N2: begin
        t_nxt     = fadd(num_r, num_r, p_r);
        state_nxt = ecsm_pkg::ST_DBL_N3;
      end
      ecsm_pkg::ST_DBL_N3: begin
        t_nxt     = fadd(t_r, num_r, p_r);
        state_nxt = ecsm_pkg::ST_DBL_NA;
      end
      ecsm_pkg::ST_DBL_NA: begin
        num_nxt   = fadd(t_r, ared_r, p_r);
        r0_nxt    = p_r;
        r1_nxt    = fadd(ry_r, ry_r, p_r);
        t0_nxt    = '0;
        t1_nxt    = FW'(1);
        state_nxt = ecsm_pkg::ST_INV;
      end
      ecsm_pkg::ST_ADD: begin
        is_add_nxt = 1'b1;
        if (rx_r == '0 && ry_r == '0) begin
          rx_nxt    = bx_r;
          ry_nxt    = by_r;
          state_nxt = ecsm_pkg::ST_LOOP;
        end else if (bx_r == '0 && by_r == '0) begin
          state_nxt = ecsm_pkg::ST_LOOP;
        end else if (rx_r == bx_r) begin
          if (ry_r == by_r) begin
            state_nxt = ecsm_pkg::ST_DBL;
          end else begin
            rx_nxt    = '0;
            ry_nxt    = '0;
            state_nxt = ecsm_pkg::ST_LOOP;
          end
        end else begin
          num_nxt   = fsub(by_r, ry_r, p_r);
          r0_nxt    = p_r;
          r1_nxt    = fsub(bx_r, rx_r, p_r);
          t0_nxt    = '0;
          t1_nxt    = FW'(1);
          s_nxt     = fadd(rx_r, bx_r, p_r);
          state_nxt = ecsm_pkg::ST_INV;
        end
      end
      ecsm_pkg::ST_INV: begin
        // one Euclid step per pass; the unit forms q*t1 as quotient bits arrive
        if (!launched_r) begin
          if (r1_r == '0) begin
            inv_nxt   = (r0_r == FW'(1)) ? t0_r : '0;
            state_nxt = ecsm_pkg::ST_LAM;
          end else begin
            u_start      = 1'b1;
            launched_nxt = 1'b1;
          end
        end else if (u_done) begin
          launched_nxt = 1'b0;
          r0_nxt       = r1_r;
          r1_nxt       = u_rem;
          t0_nxt       = t1_r;
          t1_nxt       = fsub(t0_r, u_acc, p_r);
        end
      end
      ecsm_pkg::ST_LAM, ecsm_pkg::ST_LSQ, ecsm_pkg::ST_MY: begin
        if (!launched_r) begin
          u_start      = 1'b1;
          launched_nxt = 1'b1;
        end else if (u_done) begin
          launched_nxt = 1'b0;
          if (state_r == ecsm_pkg::ST_LAM) begin
            lam_nxt   = u_acc;
            state_nxt = ecsm_pkg::ST_LSQ;
          end else if (state_r == ecsm_pkg::ST_LSQ) begin
            t_nxt     = u_acc;
            state_nxt = ecsm_pkg::ST_NEWX;
          end else begin
            t_nxt     = u_acc;
            state_nxt = ecsm_pkg::ST_NEWY;
          end
        end
      end
      ecsm_pkg::ST_NEWX: begin
        tx_nxt    = fsub(t_r, s_r, p_r);
        state_nxt = ecsm_pkg::ST_DIFF;
      end
      ecsm_pkg::ST_DIFF: begin
        s_nxt     = fsub(rx_r, tx_r, p_r);
        state_nxt = ecsm_pkg::ST_MY;
      end
      ecsm_pkg::ST_NEWY: begin
        ry_nxt    = fsub(t_r, ry_r, p_r);
        rx_nxt    = tx_r;
        state_nxt = after_st;
      end
      default: begin
        state_nxt = ecsm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ecsm_pkg::ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prime_r     <= FW'(ecsm_pkg::PRIME_RST);
      curve_a_r   <= FW'(ecsm_pkg::CURVE_A_RST);
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
      prime_r     <= prime_nxt;
      curve_a_r   <= curve_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_add_r <= is_add_nxt;
    idx_r    <= idx_nxt;
    k_r      <= k_nxt;
    p_r      <= p_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    ared_r   <= ared_nxt;
    bx_r     <= bx_nxt;
    by_r     <= by_nxt;
    rx_r     <= rx_nxt;
    ry_r     <= ry_nxt;
    num_r    <= num_nxt;
    t_r      <= t_nxt;
    s_r      <= s_nxt;
    lam_r    <= lam_nxt;
    inv_r    <= inv_nxt;
    r0_r     <= r0_nxt;
    r1_r     <= r1_nxt;
    t0_r     <= t0_nxt;
    t1_r     <= t1_nxt;
    tx_r     <= tx_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != ecsm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hdl/ecsm_chk.sv
`timescale 1ns / 1ps

module ecsm_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input ecsm_pkg::ecsm_out_t out_data
);

  // a result only appears once the block has gone idle
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // an accepted beat either starts work or answers at once
  a_accept_acts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted beat dropped");

  // leaving busy always delivers a result
  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("work ended without a result");

  // no repeated result without a new beat
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !start |=> !out_valid)
    else $error("result repeated");

  // an error status only comes back straight after an accepted beat
  a_error_quick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> $past(start) && !$past(busy))
    else $error("late error status");

endmodule

bind ec_point_scalar_multiply_top ecsm_chk u_ecsm_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_data (out_data)
);

FILE: sim/ecsm_checker.sv
`timescale 1ns / 1ps

module ecsm_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  ecsm_pkg::ecsm_in_t             in_data,
  input  logic                           out_valid,
  input  ecsm_pkg::ecsm_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [ecsm_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ecsm_pkg::IO_W-1:0]      cfg_wdata,
  output int                             fail_count,
  output int                             pending
);

  logic [63:0]         shadow_p;
  logic [63:0]         shadow_a;
  ecsm_pkg::ecsm_out_t expected_points[$];

  function automatic logic [63:0] fadd(logic [63:0] x, logic [63:0] y, logic [63:0] p);
    logic [63:0] gap;
    gap = p - y;
    return (x >= gap) ? x - gap : x + y;
  endfunction

  function automatic logic [63:0] fsub(logic [63:0] x, logic [63:0] y, logic [63:0] p);
    return (x >= y) ? x - y : x + (p - y);
  endfunction

  function automatic logic [63:0] fmul(logic [63:0] x, logic [63:0] y, logic [63:0] p);
    logic [63:0] acc;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = fadd(acc, acc, p);
      if (y[i]) acc = fadd(acc, x, p);
    end
    return acc;
  endfunction

  // extended Euclid; no inverse gives zero
  function automatic logic [63:0] finv(logic [63:0] v, logic [63:0] p);
    logic [63:0] r0, r1, t0, t1, q, tmp;
    r0 = p;
    r1 = v;
    t0 = '0;
    t1 = 64'd1;
    while (r1 != 0) begin
      q   = r0 / r1;
      tmp = r0 - q * r1;
      r0  = r1;
      r1  = tmp;
      tmp = fsub(t0, fmul(q % p, t1, p), p);
      t0  = t1;
      t1  = tmp;
    end
    return (r0 == 64'd1) ? t0 : '0;
  endfunction

  function automatic void dbl_point(inout logic [63:0] x, inout logic [63:0] y,
                                    input logic [63:0] p, input logic [63:0] a);
    logic [63:0] num, lam, rx;
    if (y == 0) begin
      x = '0;
      y = '0;
      return;
    end
    num = fmul(x, x, p);
    num = fadd(fadd(fadd(num, num, p), num, p), a, p);
    lam = fmul(num, finv(fadd(y, y, p), p), p);
    rx  = fsub(fmul(lam, lam, p), fadd(x, x, p), p);
    y   = fsub(fmul(lam, fsub(x, rx, p), p), y, p);
    x   = rx;
  endfunction

  function automatic void ec_add(inout logic [63:0] x, inout logic [63:0] y,
                                 input logic [63:0] qx, input logic [63:0] qy,
                                 input logic [63:0] p, input logic [63:0] a);
    logic [63:0] lam, rx;
    if (x == 0 && y == 0) begin
      x = qx;
      y = qy;
      return;
    end
    if (qx == 0 && qy == 0) return;
    if (x == qx) begin
      if (y == qy) dbl_point(x, y, p, a);
      else begin
        x = '0;
        y = '0;
      end
      return;
    end
    lam = fmul(fsub(qy, y, p), finv(fsub(qx, x, p), p), p);
    rx  = fsub(fsub(fmul(lam, lam, p), x, p), qx, p);
    y   = fsub(fmul(lam, fsub(x, rx, p), p), y, p);
    x   = rx;
  endfunction

  function automatic ecsm_pkg::ecsm_out_t scalar_multiple(ecsm_pkg::ecsm_in_t item,
                                                          logic [63:0] p,
                                                          logic [63:0] a_raw);
    ecsm_pkg::ecsm_out_t res;
    logic [63:0]         k, bx, by, a, rx, ry;
    int                  top;
    k = 64'(item.scalar);
    res = '0;
    if (k == 0) begin
      res.result_x = item.point_x;
      res.result_y = item.point_y;
      res.status   = 1'b1;
      return res;
    end
    if (p < 2) return res;
    bx  = 64'(item.point_x) % p;
    by  = 64'(item.point_y) % p;
    a   = a_raw % p;
    top = 63;
    while (top > 0 && !k[top]) top--;
    rx = bx;
    ry = by;
    for (int i = top - 1; i >= 0; i--) begin
      dbl_point(rx, ry, p, a);
      if (k[i]) ec_add(rx, ry, bx, by, p, a);
    end
    res.result_x = rx[31:0];
    res.result_y = ry[31:0];
    return res;
  endfunction

  assign pending = expected_points.size();

  always @(posedge clk) begin
    ecsm_pkg::ecsm_out_t want;
    if (!rst_n) begin
      shadow_p   <= 64'(ecsm_pkg::PRIME_RST);
      shadow_a   <= 64'(ecsm_pkg::CURVE_A_RST);
      fail_count <= 0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == ecsm_pkg::CFG_PRIME) shadow_p <= 64'(cfg_wdata);
        else if (cfg_addr == ecsm_pkg::CFG_CURVE_A) shadow_a <= 64'(cfg_wdata);
      end
      if (start && !busy)
        expected_points.insert(expected_points.size(),
                               scalar_multiple(in_data, shadow_p, shadow_a));
      if (out_valid) begin
        if (expected_points.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat: %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_points.pop_front();
          if (want.result_x !== out_data.result_x || want.result_y !== out_data.result_y ||
              want.status !== out_data.status) begin
            if (fail_count < 10)
              $display("mismatch: expected x=%h y=%h st=%b, got x=%h y=%h st=%b",
                       want.result_x, want.result_y, want.status,
                       out_data.result_x, out_data.result_y, out_data.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam longint CYCLE_LIMIT = 40_000_000;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  ecsm_pkg::ecsm_in_t             in_data;
  logic                           out_valid;
  ecsm_pkg::ecsm_out_t            out_data;
  logic                           cfg_we;
  logic [ecsm_pkg::CFG_IDX_W-1:0] cfg_addr;
  logic [ecsm_pkg::IO_W-1:0]      cfg_wdata;
  int                             fail_count;
  int                             pending;
  longint                         cycles;
  bit                             idle_on;

  ec_point_scalar_multiply_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  ecsm_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata), .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ec_point_scalar_multiply_top regression: fail");
      $finish;
    end
  end

  // offer one beat and hold it until taken
  task automatic send_point(input ecsm_pkg::ecsm_in_t item);
    bit taken;
    if (idle_on && $urandom_range(0, 99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic set_field(input logic [31:0] p, input logic [31:0] a);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= ecsm_pkg::CFG_PRIME;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_addr  <= ecsm_pkg::CFG_CURVE_A;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic ecsm_pkg::ecsm_in_t pick(logic [31:0] s, logic [31:0] x,
                                              logic [31:0] y);
    ecsm_pkg::ecsm_in_t it;
    it.scalar  = s;
    it.point_x = x;
    it.point_y = y;
    return it;
  endfunction

  // random item; scalar length capped so that slow fields stay short
  task automatic send_random(input logic [31:0] p, input int max_bits);
    logic [31:0] s, x, y;
    int          nb, roll;
    nb = $urandom_range(1, max_bits);
    s  = ($urandom & ((32'd1 << nb) - 1)) | (32'd1 << (nb - 1));
    if ($urandom_range(0, 11) == 0) s = '0;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      x = '0;
      y = '0;
    end else if (roll == 1 || p < 2) begin
      x = $urandom;
      y = $urandom;
    end else begin
      x = $urandom % p;
      y = $urandom % p;
    end
    send_point(pick(s, x, y));
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    idle_on   = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset field: p 17, a 2
    send_point(pick(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_point(pick(32'd1, 32'd5, 32'd1));
    send_point(pick(32'd2, 32'd5, 32'd1));
    send_point(pick(32'd3, 32'd5, 32'd1));
    send_point(pick(32'd2, 32'd3, 32'd0));
    send_point(pick(32'd5, 32'd0, 32'd0));
    send_point(pick(32'd7, 32'd22, 32'd18));
    send_point(pick(32'd6, 32'd17, 32'd17));
    send_point(pick(32'hFFFF_FFFF, 32'd5, 32'd1));
    send_point(pick(32'h8000_0000, 32'd6, 32'd3));
    for (int i = 0; i < 15; i++) send_random(32'd17, 12);

    // modulus below two: any nonzero scalar gives infinity
    set_field(32'd1, 32'hFFFF_FFFF);
    send_point(pick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
    for (int i = 0; i < 6; i++) send_random(32'd1, 32);
    set_field(32'd0, 32'd0);
    for (int i = 0; i < 6; i++) send_random(32'd0, 32);

    // composite modulus exercises missing inverses
    set_field(32'd15, 32'd7);
    for (int i = 0; i < 12; i++) send_random(32'd15, 10);

    set_field(32'd3, 32'd0);
    for (int i = 0; i < 10; i++) send_random(32'd3, 10);

    // largest field: short scalars, one full-length one
    set_field(32'hFFFF_FFFB, $urandom);
    send_point(pick(32'hFFFF_FFFF, $urandom, $urandom));
    idle_on = 1'b0;
    for (int i = 0; i < 10; i++) send_random(32'hFFFF_FFFB, 4);
    idle_on = 1'b1;

    set_field(32'd1009, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) send_random(32'd1009, 8);
    drain();
    for (int i = 0; i < 10; i++) send_random(32'd1009, 8);

    set_field(32'd97, 32'd96);
    for (int i = 0; i < 12; i++) send_random(32'd97, 14);

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ec_point_scalar_multiply_top regression: pass");
    end else begin
      $display("ec_point_scalar_multiply_top regression: fail");
    end
    $finish;
  end

endmodule
